/* rtl/edd_pkg.sv */
// Shared constants, types and register codes for the error diffusion dither.
`default_nettype none
package edd_pkg;

   localparam int PIX_W     = 8;
   localparam int CFG_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int ROW_W     = 8;
   localparam int ERR_W     = 5;
   localparam int ROW_ERR_W = 9;
   localparam int ACC_W     = 14;

   localparam int MAX_WIDTH_DEF    = 256;
   localparam int MAX_HEIGHT       = 256;
   localparam int CFG_WIDTH_RESET  = 256;
   localparam int CFG_HEIGHT_RESET = 256;

   // floor(x / 3) for x below 2046 as (x * 683) >> 11
   localparam int GRAY_RECIP = 683;
   localparam int GRAY_SHIFT = 11;
   localparam int SUM_W      = PIX_W + 2;
   localparam int PROD_W     = SUM_W + 10;

   localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd240;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   typedef logic signed [ERR_W-1:0]     err_type;
   typedef logic signed [ROW_ERR_W-1:0] row_err_type;

   typedef struct packed {
      logic first_row;
      logic col_zero;
      logic last_col;
      logic last_row;
   } pos_type;

endpackage
`default_nettype wire

/* rtl/edd_req_if.sv */
// Input pixel channel: valid, ready and one RGB word.
`default_nettype none
interface edd_req_if;
   import edd_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

/* rtl/edd_rsp_if.sv */
// Result channel: valid, ready and one dithered gray word.
`default_nettype none
interface edd_rsp_if;
   import edd_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] gray_level;
   logic             frame_last;
   modport source (output valid, gray_level, frame_last, input ready);
   modport sink   (input valid, gray_level, frame_last, output ready);
endinterface
`default_nettype wire

/* rtl/edd_line_ram.sv */
// Error line memory: one write port, one read port with registered data.
`default_nettype none
module edd_line_ram #(
   parameter int DEPTH = 256,
   parameter int DATA_W = 9
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/edd_quant.sv */
// Adds diffused error to a gray value and quantizes it to sixteen levels.
`default_nettype none
module edd_quant (
   input  wire logic [edd_pkg::PIX_W-1:0] gray,
   input  wire edd_pkg::err_type          prev_err,
   input  wire edd_pkg::row_err_type      row_err,
   output logic      [edd_pkg::PIX_W-1:0] level,
   output edd_pkg::err_type               err
);
   import edd_pkg::*;

   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] prev_ext;
   logic [PIX_W-1:0]        sat;
   logic [PIX_W:0]          rounded;
   logic signed [PIX_W+1:0] diff;

   always_comb begin
      prev_ext = ACC_W'(prev_err);
      // gray in sixteenths, plus 7/16 from the left and the line share
      acc = $signed({2'b00, gray, 4'b0000}) + (prev_ext <<< 3) - prev_ext
            + ACC_W'(row_err);
      if (acc[ACC_W-1]) begin
         sat = '0;
      end else if (|acc[ACC_W-2:PIX_W+4]) begin
         sat = '1;
      end else begin
         sat = acc[PIX_W+3:4];
      end
      rounded = {1'b0, sat} + (PIX_W+1)'(8);
      // cap at the top level instead of wrapping
      if (rounded[PIX_W]) begin
         level = LEVEL_MAX;
      end else begin
         level = {rounded[PIX_W-1:4], 4'b0000};
      end
      diff = $signed({2'b00, sat}) - $signed({2'b00, level});
      err  = diff[ERR_W-1:0];
   end

endmodule
`default_nettype wire

/* rtl/error_diffusion_dither_top.sv */
// Top level: raster control, error line read-modify-write and output stage.
// A pixel word accepted on req is held in the compute stage register, then in the
// output stage register, before it shows on rsp. One pixel per cycle while rsp is not
// stalled, set by the carry of the right-hand error and one line RAM read plus one write per pixel.
// Reset (synchronous): clears counters, handshake state and width/height to
// 256; the line RAM is not cleared, the first row of a frame ignores it.
`default_nettype none
module error_diffusion_dither_top #(
   parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   edd_req_if.sink                            req_chan,
   edd_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [edd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [edd_pkg::CFG_W-1:0]     csr_wdata
);
   import edd_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int RST_WIDTH = (CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET;
   localparam logic [COL_W-1:0] WIDTH_IDX_RST = COL_W'(RST_WIDTH - 1);
   localparam logic [ROW_W-1:0] HEIGHT_IDX_RST = ROW_W'(CFG_HEIGHT_RESET - 1);

   // raster control
   logic [COL_W-1:0] width_idx_ff, width_idx_in;
   logic [ROW_W-1:0] height_idx_ff, height_idx_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // compute stage
   logic             b_valid_ff, b_valid_in;
   logic [PIX_W-1:0] b_gray_ff, b_gray_in;
   logic [COL_W-1:0] b_col_ff, b_col_in;
   pos_type          b_pos_ff, b_pos_in;
   logic             fwd_ff, fwd_in;
   row_err_type      fwd_data_ff, fwd_data_in;
   err_type          e_prev_ff, e_prev_in;
   row_err_type      pend_ff, pend_in;
   row_err_type      tail_ff, tail_in;

   // output stage
   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_level_ff, out_level_in;
   logic             out_last_ff, out_last_in;

   logic              csr_hit;
   logic              acc_go;
   logic              b_fire;
   pos_type           pos;
   logic [SUM_W-1:0]  rgb_sum;
   logic [PROD_W-1:0] rgb_prod;
   logic              wen;
   logic [COL_W-1:0]  waddr;
   row_err_type       wdata;
   logic [ROW_ERR_W-1:0] ram_q;
   row_err_type       row_err;
   err_type           prev_err;
   err_type           err;
   logic [PIX_W-1:0]  level;
   row_err_type       err9;
   row_err_type       spread;

   assign csr_hit = csr_we && (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT);
   assign b_fire  = b_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!b_valid_ff || b_fire);
   assign acc_go  = req_chan.valid && req_chan.ready;

   assign pos.first_row = (row_ff == '0);
   assign pos.col_zero  = (col_ff == '0);
   assign pos.last_col  = (col_ff == width_idx_ff);
   assign pos.last_row  = (row_ff == height_idx_ff);

   assign rgb_sum  = SUM_W'(req_chan.red) + SUM_W'(req_chan.green) + SUM_W'(req_chan.blue);
   assign rgb_prod = PROD_W'(rgb_sum) * PROD_W'(GRAY_RECIP);

   always_comb begin
      width_idx_in  = width_idx_ff;
      height_idx_in = height_idx_ff;
      if (csr_we && csr_index == REG_IMAGE_WIDTH) begin
         if (csr_wdata == '0) begin
            width_idx_in = '0;
         end else if (int'(csr_wdata) > MAX_WIDTH) begin
            width_idx_in = COL_W'(MAX_WIDTH - 1);
         end else begin
            width_idx_in = COL_W'(csr_wdata - 1'b1);
         end
      end
      if (csr_we && csr_index == REG_IMAGE_HEIGHT) begin
         if (csr_wdata == '0) begin
            height_idx_in = '0;
         end else if (int'(csr_wdata) > MAX_HEIGHT) begin
            height_idx_in = ROW_W'(MAX_HEIGHT - 1);
         end else begin
            height_idx_in = ROW_W'(csr_wdata - 1'b1);
         end
      end
   end

   // advance the raster position on each accepted word; restart on a width or height register write
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (acc_go) begin
         if (pos.last_col) begin
            col_in = '0;
            row_in = pos.last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // line share: the last column lives in a register, the first row reads zero
   always_comb begin
      if (b_pos_ff.first_row) begin
         row_err = '0;
      end else if (b_pos_ff.last_col) begin
         row_err = tail_ff;
      end else if (fwd_ff) begin
         row_err = fwd_data_ff;
      end else begin
         row_err = $signed(ram_q);
      end
      prev_err = b_pos_ff.col_zero ? err_type'(0) : e_prev_ff;
   end

   edd_quant u_quant (
      .gray     (b_gray_ff),
      .prev_err (prev_err),
      .row_err  (row_err),
      .level    (level),
      .err      (err)
   );

   always_comb begin
      err9   = ROW_ERR_W'(err);
      spread = (err9 <<< 2) + err9 + ROW_ERR_W'(prev_err);
      wdata  = pend_ff + (err9 <<< 1) + err9;
      wen    = b_fire && !b_pos_ff.col_zero;
      waddr  = b_col_ff - 1'b1;
   end

   edd_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (ROW_ERR_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wen),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (acc_go),
      .rd_addr (col_ff),
      .rd_data (ram_q)
   );

   always_comb begin
      b_valid_in  = b_valid_ff;
      b_gray_in   = b_gray_ff;
      b_col_in    = b_col_ff;
      b_pos_in    = b_pos_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (b_fire) begin
         b_valid_in = 1'b0;
         fwd_in     = 1'b0;
      end
      if (acc_go) begin
         b_valid_in  = 1'b1;
         b_gray_in   = rgb_prod[GRAY_SHIFT+PIX_W-1:GRAY_SHIFT];
         b_col_in    = col_ff;
         b_pos_in    = pos;
         // bypass a write landing on the entry read at the same edge
         fwd_in      = wen && (waddr == col_ff);
         fwd_data_in = wdata;
      end
      e_prev_in = b_fire ? err : e_prev_ff;
      pend_in   = b_fire ? spread : pend_ff;
      tail_in   = (b_fire && b_pos_ff.last_col) ? spread : tail_ff;

      out_valid_in = out_valid_ff;
      out_level_in = out_level_ff;
      out_last_in  = out_last_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (b_fire) begin
         out_valid_in = 1'b1;
         out_level_in = level;
         out_last_in  = b_pos_ff.last_col && b_pos_ff.last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_idx_ff  <= WIDTH_IDX_RST;
         height_idx_ff <= HEIGHT_IDX_RST;
         col_ff        <= '0;
         row_ff        <= '0;
         b_valid_ff    <= 1'b0;
         fwd_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         width_idx_ff  <= width_idx_in;
         height_idx_ff <= height_idx_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         b_valid_ff    <= b_valid_in;
         fwd_ff        <= fwd_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_gray_ff    <= b_gray_in;
      b_col_ff     <= b_col_in;
      b_pos_ff     <= b_pos_in;
      fwd_data_ff  <= fwd_data_in;
      e_prev_ff    <= e_prev_in;
      pend_ff      <= pend_in;
      tail_ff      <= tail_in;
      out_level_ff <= out_level_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.gray_level = out_level_ff;
   assign rsp_chan.frame_last = out_last_ff;

   a_fwd_has_pixel : assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> b_valid_ff)
      else $error("bypass flag set with no pixel in the compute stage");

   a_col_in_row : assert property (@(posedge clock) disable iff (reset)
      col_ff <= width_idx_ff)
      else $error("column counter beyond row width");

   a_row_wrap : assert property (@(posedge clock) disable iff (reset)
      acc_go && pos.last_col |=> col_ff == '0)
      else $error("column counter did not wrap after last column");

   a_level_step : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.gray_level[3:0] == 4'd0)
      else $error("output level is not a multiple of 16");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the error diffusion dither: predictor, drivers and checks.
`timescale 1ns / 100ps
module tb_top;
   import edd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam int RANDOM_PIXELS = 880;
   localparam int SEND_IDLE [4] = '{0, 67, 0, 10};
   localparam int RSP_STALL [4] = '{0, 0, 67, 10};
   // {red, green, blue}
   localparam logic [23:0] DIRECTED_PIX [12] = '{
      24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h070707, 24'h080808, 24'hF8F8F8,
      24'hFFFFFF, 24'h181818, 24'h000000, 24'h878889, 24'hFFFFFE, 24'h010203};

   typedef struct {
      logic [PIX_W-1:0] level;
      logic             last;
   } gray_word_type;

   class dither_scoreboard;
      logic [CFG_W-1:0]        width_reg;
      logic [CFG_W-1:0]        height_reg;
      row_err_type             below_err [MAX_WIDTH_DEF];
      logic signed [PIX_W-1:0] right_err;
      logic [ROW_W-1:0]        col_pos;
      logic [ROW_W-1:0]        row_pos;
      gray_word_type           pending [$];
      int                      mismatches;
      int                      pixels_in;
      int                      frame_ends;

      function new();
         width_reg  = CFG_W'(CFG_WIDTH_RESET);
         height_reg = CFG_W'(CFG_HEIGHT_RESET);
         mismatches = 0;
         pixels_in  = 0;
         frame_ends = 0;
         restart();
      endfunction

      function void restart();
         foreach (below_err[i]) below_err[i] = '0;
         right_err = '0;
         col_pos   = '0;
         row_pos   = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == REG_IMAGE_WIDTH) begin
            width_reg = val;
            restart();
         end else if (idx == REG_IMAGE_HEIGHT) begin
            height_reg = val;
            restart();
         end
      endfunction

      // Dither one pixel word and queue the gray word it must produce.
      function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
         int            w, h, col, gray, acc, v, lvl, e, left_share;
         bit            last_col, last_row;
         gray_word_type exp_w;
         w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
         h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
         col = int'(col_pos);
         last_col = (col + 1 >= w);
         last_row = (int'(row_pos) + 1 >= h);
         gray = (int'(r) + int'(g) + int'(b)) / 3;
         acc = gray * 16 + int'(right_err) + int'(below_err[col]);
         if (acc < 0) v = 0;
         else v = (acc / 16 > 255) ? 255 : acc / 16;
         lvl = ((v + 8) / 16) * 16;
         if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
         e = v - lvl;
         // lower-right share of the left neighbor, recovered from its right carry
         left_share = (col > 0) ? int'(right_err) / 7 : 0;
         if (!last_row) begin
            if (col > 0) below_err[col-1] = row_err_type'(int'(below_err[col-1]) + 3 * e);
            below_err[col] = row_err_type'(5 * e + left_share);
         end else begin
            below_err[col] = '0;
         end
         right_err = last_col ? '0 : 8'(7 * e);
         exp_w.level = lvl[PIX_W-1:0];
         exp_w.last  = last_col && last_row;
         pending.push_back(exp_w);
         pixels_in++;
         if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
         end else begin
            col_pos = col_pos + 1'b1;
         end
      endfunction

      function void check_word(logic [PIX_W-1:0] lvl, logic last);
         gray_word_type exp_w;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected gray word: level %0d last %0b", $time, lvl, last);
            return;
         end
         exp_w = pending.pop_front();
         if (exp_w.last) frame_ends++;
         if (exp_w.level !== lvl || exp_w.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: gray word mismatch: expected level %0d last %0b, ",
                         "got level %0d last %0b"},
                        $time, exp_w.level, exp_w.last, lvl, last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   dither_scoreboard     sb = new();

   edd_req_if req_chan ();
   edd_rsp_if rsp_chan ();

   error_diffusion_dither_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_word(rsp_chan.gray_level, rsp_chan.frame_last);
   end

   initial begin
      #2000000;
      $display("timeout: %0d gray words still outstanding", sb.pending.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.red   <= r;
      req_chan.green <= g;
      req_chan.blue  <= b;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_pixel(r, g, b);
      @(negedge clock);
   endtask

   // Drop valid and hold until every queued gray word has come out.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   initial begin
      int unsigned      settings;
      int unsigned      count;
      int unsigned      k;
      int               phase;
      int               sent;
      logic [CFG_W-1:0] w_val;
      logic [CFG_W-1:0] h_val;
      logic [PIX_W-1:0] r, g, b;
      int               failures;

      settings = 0;
      sent = 0;
      req_chan.valid = 1'b0;
      req_chan.red   = '0;
      req_chan.green = '0;
      req_chan.blue  = '0;
      csr_we    = 1'b0;
      csr_index = REG_IMAGE_WIDTH;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // a few words at the reset frame size
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h08, 8'h08, 8'h08);
      drain();

      // one full 4x3 frame; a spare register write mid-frame must not restart it
      write_reg(REG_IMAGE_WIDTH, 9'd4);
      write_reg(REG_IMAGE_HEIGHT, 9'd3);
      for (int i = 0; i < 12; i++) begin
         if (i == 5) begin
            drain();
            write_reg(REG_SPARE_2, 9'h1FF);
         end
         send_pixel(DIRECTED_PIX[i][23:16], DIRECTED_PIX[i][15:8], DIRECTED_PIX[i][7:0]);
      end
      drain();

      // zero width and height act as one: every word ends a frame
      write_reg(REG_IMAGE_WIDTH, 9'd0);
      write_reg(REG_IMAGE_HEIGHT, 9'd0);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      drain();
      write_reg(REG_SPARE_3, 9'h0AA);
      send_pixel(8'h00, 8'h00, 8'h01);
      send_pixel(8'h80, 8'h7F, 8'h80);
      drain();

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = SEND_IDLE[phase];
         rsp_stall_pct = RSP_STALL[phase];
         while (sent < RANDOM_PIXELS * (phase + 1) / 4) begin
            if (phase == 0 && settings == 0) begin
               w_val = 9'h1FF;
               h_val = 9'd1;
               count = MAX_WIDTH_DEF;
            end else if (phase == 2 && settings != 0 && h_val != 9'h12C) begin
               w_val = 9'd1;
               h_val = 9'h12C;
               count = $urandom_range(40, 64);
            end else begin
               case ($urandom_range(0, 31))
                  0: begin
                     w_val = $urandom_range(0, 1) ? 9'd256 : 9'd300;
                     h_val = CFG_W'($urandom_range(1, 2));
                     count = MAX_WIDTH_DEF + $urandom_range(0, 8);
                  end
                  1, 2: begin
                     w_val = CFG_W'($urandom_range(0, 1));
                     h_val = CFG_W'($urandom_range(0, 4));
                     count = $urandom_range(2, 10);
                  end
                  default: begin
                     w_val = CFG_W'($urandom_range(1, 16));
                     h_val = CFG_W'($urandom_range(1, 8));
                     count = w_val * h_val * $urandom_range(1, 2);
                     // sometimes cut the frame short or run into the next one
                     if ($urandom_range(0, 3) == 0) count = count + $urandom_range(1, 5);
                     if (count > 120) count = 120;
                  end
               endcase
            end
            drain();
            if ($urandom_range(0, 1)) begin
               write_reg(REG_IMAGE_WIDTH, w_val);
               write_reg(REG_IMAGE_HEIGHT, h_val);
            end else begin
               write_reg(REG_IMAGE_HEIGHT, h_val);
               write_reg(REG_IMAGE_WIDTH, w_val);
            end
            settings++;
            for (int n = 0; n < count; n++) begin
               case ($urandom_range(0, 5))
                  0: begin
                     k = $urandom_range(0, 255);
                     r = PIX_W'(k); g = PIX_W'(k); b = PIX_W'(k);
                  end
                  1: begin
                     // flat gray close to a quantizer decision point
                     k = 16 * $urandom_range(0, 15) + $urandom_range(6, 10);
                     if (k > 255) k = 255;
                     r = PIX_W'(k); g = PIX_W'(k); b = PIX_W'(k);
                  end
                  2: begin
                     r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                     g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                     b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  end
                  3: begin
                     r = PIX_W'($urandom_range(0, 20));
                     g = PIX_W'($urandom_range(0, 20));
                     b = PIX_W'($urandom_range(0, 20));
                  end
                  4: begin
                     r = PIX_W'($urandom_range(235, 255));
                     g = PIX_W'($urandom_range(235, 255));
                     b = PIX_W'($urandom_range(235, 255));
                  end
                  default: begin
                     r = PIX_W'($urandom_range(0, 255));
                     g = PIX_W'($urandom_range(0, 255));
                     b = PIX_W'($urandom_range(0, 255));
                  end
               endcase
               send_pixel(r, g, b);
               sent++;
            end
         end
      end

      req_chan.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      failures = sb.mismatches + sb.pending.size();
      $display("Dithered %0d pixel words over %0d random frame sizes, %0d frame ends checked",
               sb.pixels_in, settings, sb.frame_ends);
      $display("Flow phases: free running, sender idling, receiver stalling, both; %0d failures",
               failures);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
